FILE: rtl/spq_pkg.sv
// Package for the sorted priority queue: entry type, operation and status codes.
// Used by spq_cell and sorted_priority_queue_top; depends on nothing else.
`timescale 1ns / 1ps

package spq_pkg;

	// One held entry: priority in the upper bits, data value in the lower bits
	typedef struct packed {
		logic signed [15:0] prio;
		logic signed [31:0] data;
	} entry_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic insert;  // commit an enqueue this cycle
		logic remove;  // commit a dequeue this cycle
	} cell_ctrl_t;

	// Operation codes (request tuser)
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// Status codes (result tuser)
	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_DEQUEUED = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam int unsigned OCC_W = 5;

endpackage

FILE: rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of spq_cell slots, fill count
// and registered result stage. Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH entries kept in descending priority order in a
// chain of cells; equal priorities leave first in, first out. Each request (enqueue
// or dequeue) yields one result in the cycle after it is accepted; a new request is
// taken every cycle unless m_tready stalls the result: every cell compares its entry
// with the broadcast priority in parallel and shifts toward its neighbor, so the
// per-cycle compare across the chain sets the clock. An enqueue on a full queue is
// dropped and reported as full; a dequeue on an empty queue reports empty. Occupancy
// is the count after the operation, modulo 32. Entries need no clearing after reset.
module sorted_priority_queue_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // item_value [31:0], item_priority [47:32]
	input  logic [0:0]  s_tuser,   // opcode [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_value [31:0], out_priority [47:32],
	                               // occupancy [52:48], zero [55:53]
	output logic [1:0]  m_tuser    // status [1:0]
);
	import spq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic              in_acc;
	logic              op;
	entry_t            new_entry;
	logic              full, empty;
	cell_ctrl_t        ctrl;
	logic [CW-1:0]     count_q, count_d;
	entry_t            cell_entry [DEPTH];
	logic [DEPTH-1:0]  cell_ge;

	logic              res_valid_q;
	logic [1:0]        res_status_q;
	entry_t            res_entry_q;
	logic [OCC_W-1:0]  res_occ_q;

	// Request decode
	assign s_tready       = !res_valid_q || m_tready;
	assign in_acc         = s_tvalid && s_tready;
	assign op             = s_tuser[0];
	assign new_entry.data = s_tdata[31:0];
	assign new_entry.prio = s_tdata[47:32];
	assign full           = (count_q == CW'(DEPTH));
	assign empty          = (count_q == '0);
	assign ctrl.insert    = in_acc && (op == OP_ENQUEUE) && !full;
	assign ctrl.remove    = in_acc && (op == OP_DEQUEUE) && !empty;

	// Chain of cells; the head sees a virtual neighbor that always stays ahead
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_g;
		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_g = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_g = cell_ge[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_e = cell_entry[i];
		end else begin : g_mid
			assign next_e = cell_entry[i+1];
		end
		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.prev_ge    (prev_g),
			.occupied   (count_q > CW'(i)),
			.entry      (cell_entry[i]),
			.ge         (cell_ge[i])
		);
	end

	// Fill count after this request
	always_comb begin
		count_d = count_q;
		if (ctrl.insert) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_acc) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_occ_q <= OCC_W'(count_d);
			if (op == OP_ENQUEUE) begin
				res_status_q <= full ? ST_FULL : ST_ENQUEUED;
				res_entry_q  <= '0;
			end else if (empty) begin
				res_status_q <= ST_EMPTY;
				res_entry_q  <= '0;
			end else begin
				res_status_q <= ST_DEQUEUED;
				res_entry_q  <= cell_entry[0];
			end
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tuser  = res_status_q;
	assign m_tdata  = {3'b000, res_occ_q, res_entry_q.prio, res_entry_q.data};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_ENQUEUE && full) |=> (res_status_q == ST_FULL && $stable(count_q)))
		else $error("enqueue on full queue not dropped");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
		else $error("head entries out of order");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_DEQUEUE && !empty) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("dequeue did not decrement count");
`endif

endmodule

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the incoming one,
// and keeps, loads the new entry, or takes a neighbor's entry. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t     new_entry,
	input  spq_pkg::entry_t     prev_entry,  // neighbor toward the front
	input  spq_pkg::entry_t     next_entry,  // neighbor toward the back
	input  logic                prev_ge,     // neighbor in front stays put on insert
	input  logic                occupied,    // slot index below the fill count
	output spq_pkg::entry_t     entry,
	output logic                ge           // this entry stays ahead of the new one
);
	import spq_pkg::*;

	entry_t entry_q;

	// Held entry outranks or ties the new one; ties keep arrival order
	assign ge    = occupied && (entry_q.prio >= new_entry.prio);
	assign entry = entry_q;

	// Shift toward the back on insert, toward the front on remove
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (ge) begin
				entry_q <= entry_q;
			end else if (prev_ge) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= prev_entry;
			end
		end else if (ctrl.remove) begin
			entry_q <= next_entry;
		end
	end

endmodule
